// ===== rtl/overlap_add_accumulator_defines.svh =====
// Assertion macros for the overlap-add accumulator.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef OVERLAP_ADD_ACCUMULATOR_DEFINES_SVH
`define OVERLAP_ADD_ACCUMULATOR_DEFINES_SVH
`ifndef ASSERT_OFF
`define OAA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define OAA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OAA_ASSERT(lbl, clk, rst_n, prop, msg)
`define OAA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/oaa_pkg.sv =====
// Shared types and constants for the overlap-add accumulator.
// No dependencies; imported by every module of the block.
package oaa_pkg;

    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_SIZE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HOP_SIZE   = CFG_IDX_W'(1);

    localparam logic [CFG_W-1:0] FRAME_SIZE_RST = CFG_W'(1024);
    localparam logic [CFG_W-1:0] HOP_SIZE_RST   = CFG_W'(256);

    typedef struct packed {
        logic emit;
        logic last;
    } oaa_tag_t;

endpackage

// ===== rtl/oaa_frame_if.sv =====
// Frame sample channel: valid/ready handshake carrying one sample word.
// No dependencies.
interface oaa_frame_if #(
    parameter int SAMPLE_BITS = 24
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          sample_bad;

    modport source (output valid, output sample, output sample_bad, input ready);
    modport sink   (input valid, input sample, input sample_bad, output ready);
endinterface

// ===== rtl/oaa_hop_if.sv =====
// Output hop channel: valid/ready handshake carrying one finished sample word.
// No dependencies.
interface oaa_hop_if #(
    parameter int SAMPLE_BITS = 24
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_sample;
    logic                          hop_last;

    modport source (output valid, output out_sample, output hop_last, input ready);
    modport sink   (input valid, input out_sample, input hop_last, output ready);
endinterface

// ===== rtl/oaa_ctrl.sv =====
// Configuration registers, frame position counter and ring base pointer.
// Produces the ring address and emit tags for each accepted word; uses oaa_pkg.
module oaa_ctrl #(
    parameter int MAX_FRAME = 1024,
    parameter int ADDR_W    = 10,
    parameter int CNT_W     = 11
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [oaa_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [oaa_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           accept,
    output logic [ADDR_W-1:0]              rd_addr,
    output oaa_pkg::oaa_tag_t              tag
);
    import oaa_pkg::*;

    localparam int FS_RST_EFF = (1024 > MAX_FRAME) ? MAX_FRAME : 1024;
    localparam int HS_RST_EFF = (256 > FS_RST_EFF) ? FS_RST_EFF : 256;

    logic [CFG_W-1:0]  frame_size_reg, frame_size_next;
    logic [CFG_W-1:0]  hop_size_reg, hop_size_next;
    logic [CNT_W-1:0]  fs_eff_reg, fs_eff_next;
    logic [CNT_W-1:0]  hs_eff_reg, hs_eff_next;
    logic [CNT_W-1:0]  frame_pos_reg, frame_pos_next;
    logic [ADDR_W-1:0] ring_base_reg, ring_base_next;

    logic [CNT_W-1:0]  pos;
    logic [CNT_W-1:0]  pos_inc;
    logic              wrap;
    logic [ADDR_W:0]   idx_sum;
    logic [ADDR_W:0]   base_sum;

    always_comb
    begin
        frame_size_next = frame_size_reg;
        hop_size_next   = hop_size_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_FRAME_SIZE: frame_size_next = cfg_data;
                REG_HOP_SIZE:   hop_size_next   = cfg_data;
            endcase
        end
    end

    always_comb
    begin
        if (frame_size_next == '0)
            fs_eff_next = CNT_W'(1);
        else if (32'(frame_size_next) > 32'(MAX_FRAME))
            fs_eff_next = CNT_W'(MAX_FRAME);
        else
            fs_eff_next = CNT_W'(frame_size_next);

        if (hop_size_next == '0)
            hs_eff_next = CNT_W'(1);
        else if (32'(hop_size_next) > 32'(fs_eff_next))
            hs_eff_next = fs_eff_next;
        else
            hs_eff_next = CNT_W'(hop_size_next);
    end

    always_comb
    begin
        pos     = (frame_pos_reg >= fs_eff_reg) ? '0 : frame_pos_reg;
        pos_inc = pos + CNT_W'(1);
        wrap    = (pos_inc >= fs_eff_reg);

        idx_sum = {1'b0, ring_base_reg} + {1'b0, pos[ADDR_W-1:0]};
        if (idx_sum >= (ADDR_W+1)'(MAX_FRAME))
            rd_addr = ADDR_W'(idx_sum - (ADDR_W+1)'(MAX_FRAME));
        else
            rd_addr = idx_sum[ADDR_W-1:0];

        tag.emit = (pos < hs_eff_reg);
        tag.last = (pos_inc == hs_eff_reg);

        base_sum = {1'b0, ring_base_reg} + (ADDR_W+1)'(hs_eff_reg);

        frame_pos_next = frame_pos_reg;
        ring_base_next = ring_base_reg;
        if (accept)
        begin
            if (wrap)
            begin
                frame_pos_next = '0;
                if (base_sum >= (ADDR_W+1)'(MAX_FRAME))
                    ring_base_next = ADDR_W'(base_sum - (ADDR_W+1)'(MAX_FRAME));
                else
                    ring_base_next = base_sum[ADDR_W-1:0];
            end
            else
            begin
                frame_pos_next = pos_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_size_reg <= FRAME_SIZE_RST;
            hop_size_reg   <= HOP_SIZE_RST;
            fs_eff_reg     <= CNT_W'(FS_RST_EFF);
            hs_eff_reg     <= CNT_W'(HS_RST_EFF);
            frame_pos_reg  <= '0;
            ring_base_reg  <= '0;
        end
        else
        begin
            frame_size_reg <= frame_size_next;
            hop_size_reg   <= hop_size_next;
            fs_eff_reg     <= fs_eff_next;
            hs_eff_reg     <= hs_eff_next;
            frame_pos_reg  <= frame_pos_next;
            ring_base_reg  <= ring_base_next;
        end
    end

endmodule

// ===== rtl/oaa_ring.sv =====
// Ring accumulator memory with registered read, write forwarding and a
// post-reset clearing sweep; uses oaa_pkg and the assertion macro header.
module oaa_ring #(
    parameter int MAX_FRAME   = 1024,
    parameter int ADDR_W      = 10,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_en,
    input  logic [ADDR_W-1:0]             rd_addr,
    input  logic                          wr_en,
    input  logic [ADDR_W-1:0]             wr_addr,
    input  logic signed [SAMPLE_BITS-1:0] wr_data,
    output logic signed [SAMPLE_BITS-1:0] rd_data,
    output logic                          clearing
);
    `include "overlap_add_accumulator_defines.svh"
    import oaa_pkg::*;

    logic signed [SAMPLE_BITS-1:0] mem [MAX_FRAME];

    logic signed [SAMPLE_BITS-1:0] rd_data_reg;
    logic signed [SAMPLE_BITS-1:0] byp_data_reg;
    logic                          byp_hit_reg, byp_hit_next;
    logic                          clr_active_reg, clr_active_next;
    logic [ADDR_W-1:0]             clr_addr_reg, clr_addr_next;

    logic                          mem_we;
    logic [ADDR_W-1:0]             mem_waddr;
    logic signed [SAMPLE_BITS-1:0] mem_wdata;

    always_comb
    begin
        mem_we    = clr_active_reg || wr_en;
        mem_waddr = clr_active_reg ? clr_addr_reg : wr_addr;
        mem_wdata = clr_active_reg ? '0 : wr_data;

        byp_hit_next = byp_hit_reg;
        if (rd_en)
            byp_hit_next = wr_en && (wr_addr == rd_addr);

        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg)
        begin
            if (clr_addr_reg == ADDR_W'(MAX_FRAME - 1))
                clr_active_next = 1'b0;
            else
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
        end

        rd_data  = byp_hit_reg ? byp_data_reg : rd_data_reg;
        clearing = clr_active_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (rd_en)
        begin
            rd_data_reg  <= mem[rd_addr];
            byp_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_hit_reg    <= 1'b0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else
        begin
            byp_hit_reg    <= byp_hit_next;
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
        end
    end

    `OAA_ASSERT(a_no_access_in_clear, clk, rst_n, clr_active_reg |-> !wr_en && !rd_en, "ring accessed during clear sweep")
    `OAA_ASSERT(a_clear_once, clk, rst_n, !clr_active_reg |=> !clr_active_reg, "clear sweep restarted")
    `OAA_ASSERT(a_fwd_on_collision, clk, rst_n, rd_en && wr_en && (wr_addr == rd_addr) |=> byp_hit_reg, "collision not forwarded")
    `OAA_ASSERT_ALWAYS(a_clear_after_reset, clk, !rst_n |=> clr_active_reg, "clear sweep missing after reset")

endmodule

// ===== rtl/oaa_accum.sv =====
// Accumulate stage: saturating add onto the ring slot, slot write-back and the
// output word register; uses oaa_pkg, oaa_hop_if and the assertion macro header.
module oaa_accum #(
    parameter int ADDR_W      = 10,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          sample_bad,
    input  logic [ADDR_W-1:0]             addr,
    input  oaa_pkg::oaa_tag_t             tag,
    input  logic signed [SAMPLE_BITS-1:0] acc_data,
    output logic                          stage_free,
    output logic                          wr_en,
    output logic [ADDR_W-1:0]             wr_addr,
    output logic signed [SAMPLE_BITS-1:0] wr_data,
    oaa_hop_if.source                     hops
);
    `include "overlap_add_accumulator_defines.svh"
    import oaa_pkg::*;

    localparam logic signed [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic                          s1_valid_reg, s1_valid_next;
    logic [ADDR_W-1:0]             s1_addr_reg;
    logic signed [SAMPLE_BITS-1:0] s1_x_reg;
    oaa_tag_t                      s1_tag_reg;

    logic                          out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg;
    logic                          out_last_reg;

    logic                          out_free;
    logic                          s1_fire;
    logic signed [SAMPLE_BITS:0]   sum_wide;
    logic signed [SAMPLE_BITS-1:0] sum_sat;

    always_comb
    begin
        sum_wide = {acc_data[SAMPLE_BITS-1], acc_data} + {s1_x_reg[SAMPLE_BITS-1], s1_x_reg};
        if (sum_wide[SAMPLE_BITS] != sum_wide[SAMPLE_BITS-1])
            sum_sat = sum_wide[SAMPLE_BITS] ? SAT_MIN : SAT_MAX;
        else
            sum_sat = sum_wide[SAMPLE_BITS-1:0];

        out_free   = !out_valid_reg || hops.ready;
        s1_fire    = s1_valid_reg && (!s1_tag_reg.emit || out_free);
        stage_free = !s1_valid_reg || s1_fire;

        s1_valid_next = accept || (s1_valid_reg && !s1_fire);

        out_valid_next = out_valid_reg;
        if (s1_fire && s1_tag_reg.emit)
            out_valid_next = 1'b1;
        else if (hops.ready)
            out_valid_next = 1'b0;

        wr_en   = s1_fire;
        wr_addr = s1_addr_reg;
        wr_data = s1_tag_reg.emit ? '0 : sum_sat;
    end

    always_comb
    begin
        hops.valid      = out_valid_reg;
        hops.out_sample = out_sample_reg;
        hops.hop_last   = out_last_reg;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_addr_reg <= addr;
            s1_x_reg    <= sample_bad ? '0 : sample;
            s1_tag_reg  <= tag;
        end
        if (s1_fire && s1_tag_reg.emit)
        begin
            out_sample_reg <= sum_sat;
            out_last_reg   <= s1_tag_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `OAA_ASSERT(a_s1_hold, clk, rst_n, s1_valid_reg && !s1_fire |=> s1_valid_reg && $stable(s1_addr_reg), "stalled word lost")
    `OAA_ASSERT(a_out_from_emit, clk, rst_n, $rose(out_valid_reg) |-> $past(s1_fire && s1_tag_reg.emit), "output word without emit")
    `OAA_ASSERT(a_last_is_emit, clk, rst_n, s1_valid_reg |-> s1_tag_reg.emit || !s1_tag_reg.last, "hop end on non-emitted word")

endmodule

// ===== rtl/overlap_add_accumulator.sv =====
// Overlap-add synthesis accumulator, top level; uses oaa_pkg, oaa_frame_if, oaa_hop_if,
// oaa_ctrl, oaa_ring and oaa_accum.
// Takes one frame sample word per clock, sustained while the hop output keeps draining;
// an accepted word is registered in the s1 stage, and its finished sample moves into the
// hop output register, where it is offered on hops. Each word does one read-modify-write
// of the ring memory: the slot is read in the accept cycle and written back when the word
// leaves the s1 stage, with the write forwarded when the next word hits the same slot. A
// held hop word stalls frames.ready only when the next emitted word is waiting behind it.
// After reset the ring memory is cleared one entry a cycle with frames.ready low;
// configuration writes are taken throughout and apply from the next accepted word.
module overlap_add_accumulator #(
    parameter int MAX_FRAME   = 1024,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [oaa_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [oaa_pkg::CFG_W-1:0]     cfg_data,
    oaa_frame_if.sink                     frames,
    oaa_hop_if.source                     hops
);
    import oaa_pkg::*;

    localparam int ADDR_W = $clog2(MAX_FRAME);
    localparam int CNT_W  = $clog2(MAX_FRAME + 1);

    logic                          accept;
    logic                          stage_free;
    logic                          clearing;
    logic [ADDR_W-1:0]             rd_addr;
    oaa_tag_t                      tag;
    logic                          wr_en;
    logic [ADDR_W-1:0]             wr_addr;
    logic signed [SAMPLE_BITS-1:0] wr_data;
    logic signed [SAMPLE_BITS-1:0] acc_data;

    assign frames.ready = !clearing && stage_free;
    assign accept       = frames.valid && frames.ready;

    oaa_ctrl #(
        .MAX_FRAME (MAX_FRAME),
        .ADDR_W    (ADDR_W),
        .CNT_W     (CNT_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .accept   (accept),
        .rd_addr  (rd_addr),
        .tag      (tag)
    );

    oaa_ring #(
        .MAX_FRAME   (MAX_FRAME),
        .ADDR_W      (ADDR_W),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ring (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_addr  (rd_addr),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_data  (acc_data),
        .clearing (clearing)
    );

    oaa_accum #(
        .ADDR_W      (ADDR_W),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .sample     (frames.sample),
        .sample_bad (frames.sample_bad),
        .addr       (rd_addr),
        .tag        (tag),
        .acc_data   (acc_data),
        .stage_free (stage_free),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .hops       (hops)
    );

endmodule
